// ----- sv/rsmt_pkg.sv -----
// ============================================================================
// rsmt_pkg: shared types and constants for the range-max segment tree
// Field widths, function codes and the accumulator control bundle.
// ============================================================================
package rsmt_pkg;

    localparam int DATA_W  = 48;
    localparam int FIRST_W = 10;
    localparam int END_W   = 11;

    // func field codes
    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;

    // accumulator controls, in priority order
    typedef struct packed {
        logic clear;   // acc <= 0
        logic load;    // acc <= din
        logic take;    // acc <= rdata (first node of a query)
        logic merge;   // acc <= max(acc, rdata)
    } acc_ctl_t;

endpackage

// ----- sv/rsmt_if.sv -----
// ============================================================================
// rsmt_if: request and response channels of the range-max segment tree
// Valid/ready channels; a transfer happens when valid and ready are high.
// ============================================================================
interface rsmt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [rsmt_pkg::FIRST_W-1:0]   first_index;
    logic [rsmt_pkg::END_W-1:0]     end_index;
    rsmt_pkg::data_t                value;

    modport source (output valid, func, first_index, end_index, value, input ready);
    modport sink   (input valid, func, first_index, end_index, value, output ready);
endinterface

interface rsmt_rsp_if;
    logic            valid;
    logic            ready;
    rsmt_pkg::data_t range_max;

    modport source (output valid, range_max, input ready);
    modport sink   (input valid, range_max, output ready);
endinterface

// ----- sv/rsmt_ram.sv -----
// ============================================================================
// rsmt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module rsmt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rsmt_acc.sv -----
// ============================================================================
// rsmt_acc: shared max unit and accumulator
// One signed 48-bit compare, used by both the query walk and the write walk.
// ============================================================================
module rsmt_acc (
    input  logic               clk,
    input  rsmt_pkg::acc_ctl_t ctl,
    input  rsmt_pkg::data_t    din,
    input  rsmt_pkg::data_t    rdata,
    output rsmt_pkg::data_t    acc,
    output rsmt_pkg::data_t    acc_next
);

    rsmt_pkg::data_t acc_reg;
    rsmt_pkg::data_t mx;

    always_comb
    begin
        mx = (acc_reg > rdata) ? acc_reg : rdata;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.load)
        begin
            acc_next = din;
        end
        else if (ctl.take)
        begin
            acc_next = rdata;
        end
        else if (ctl.merge)
        begin
            acc_next = mx;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- sv/range_max_segment_tree_top.sv -----
// ============================================================================
// range_max_segment_tree_top: range-maximum segment tree with point writes
// Node store in one RAM, walked by a small sequencer around one max unit.
// ============================================================================
//
//  channel | dir | fields                                   | notes
//  --------+-----+------------------------------------------+---------------------
//  req     | in  | func, first_index, end_index, value      | func 0 query, 1 write
//  rsp     | out | range_max                                | one per query only
//
//  Walks: a write stores the leaf, then updates each ancestor after its sibling fetch;
//  a query runs a left and a right step per tree level, then a last bounds check and
//  the result load. The single node RAM read port sets this: one fetch a cycle.
//  Reset: the node RAM is swept to zero, one entry a cycle, all 2*P entries; req.ready low.
//  Stalls: the result register lets the next request in while rsp waits; a query that
//  ends while rsp is still full holds.
//
module range_max_segment_tree_top #(
    parameter int LEAVES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    rsmt_req_if.sink    req,
    rsmt_rsp_if.source  rsp
);

    // tree geometry: P leaves slots, nodes 1..2P-1, root at 1
    localparam int          LG = $clog2(LEAVES);
    localparam int unsigned P  = 32'd1 << LG;
    localparam int          NW = LG + 1;   // node address width
    localparam int          CW = LG + 2;   // query bounds reach 2P

    // sequencer states
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WLEAF = 3'd2;
    localparam logic [2:0] S_WRD   = 3'd3;
    localparam logic [2:0] S_WUP   = 3'd4;
    localparam logic [2:0] S_QL    = 3'd5;
    localparam logic [2:0] S_QR    = 3'd6;
    localparam logic [2:0] S_QEND  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [NW-1:0] node_reg, node_next;
    logic [CW-1:0] l_reg, l_next;
    logic [CW-1:0] r_reg, r_next;
    logic          mrg_reg, mrg_next;      // read data arrives this cycle (query)
    logic          found_reg, found_next;
    logic          out_valid_reg, out_valid_next;
    rsmt_pkg::data_t out_data_reg;
    logic          out_load;

    // RAM ports
    logic                we, re;
    logic [NW-1:0]       waddr, raddr;
    rsmt_pkg::data_t     wdata, rdata;

    // shared max unit
    rsmt_pkg::acc_ctl_t  ctl;
    rsmt_pkg::data_t     acc, acc_next;

    // request decode
    logic [31:0]   lo32, hi32, hi_clip;
    logic          q_empty, w_ok, xfer;
    logic [NW-1:0] parent, sibling;
    logic [CW-1:0] r_dec;

    assign lo32    = 32'(req.first_index);
    assign hi32    = 32'(req.end_index);
    assign hi_clip = (hi32 > 32'(LEAVES)) ? 32'(LEAVES) : hi32;
    assign q_empty = (lo32 >= hi_clip);
    assign w_ok    = (lo32 < 32'(LEAVES));
    assign xfer    = req.valid && req.ready;

    assign parent  = {1'b0, node_reg[NW-1:1]};
    assign sibling = node_reg ^ NW'(1);
    assign r_dec   = r_reg - CW'(1);

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        node_next  = node_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        mrg_next   = 1'b0;
        found_next = found_reg | mrg_reg;
        out_load   = 1'b0;
        we         = 1'b0;
        waddr      = node_reg;
        wdata      = acc;
        re         = 1'b0;
        raddr      = sibling;
        ctl        = '0;
        // query merges land in the cycle after their read
        ctl.take   = mrg_reg && !found_reg;
        ctl.merge  = mrg_reg && found_reg;

        case (state_reg)
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + NW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (xfer)
                begin
                    node_next  = NW'(lo32 + 32'(P));
                    l_next     = CW'(lo32 + 32'(P));
                    r_next     = CW'(hi_clip + 32'(P));
                    found_next = 1'b0;
                    if (req.func == rsmt_pkg::FUNC_WRITE)
                    begin
                        ctl.load   = 1'b1;
                        state_next = w_ok ? S_WLEAF : S_IDLE;
                    end
                    else
                    begin
                        ctl.clear  = 1'b1;
                        state_next = q_empty ? S_QEND : S_QL;
                    end
                end
            end
            S_WLEAF:
            begin
                // store the leaf and fetch its sibling together
                we         = 1'b1;
                waddr      = node_reg;
                wdata      = acc;
                re         = 1'b1;
                raddr      = sibling;
                state_next = S_WUP;
            end
            S_WRD:
            begin
                re         = 1'b1;
                raddr      = sibling;
                state_next = S_WUP;
            end
            S_WUP:
            begin
                ctl.take   = 1'b0;
                ctl.merge  = 1'b1;
                we         = 1'b1;
                waddr      = parent;
                wdata      = acc_next;
                node_next  = parent;
                state_next = (parent == NW'(1)) ? S_IDLE : S_WRD;
            end
            S_QL:
            begin
                if (l_reg < r_reg)
                begin
                    if (l_reg[0])
                    begin
                        re       = 1'b1;
                        raddr    = l_reg[NW-1:0];
                        mrg_next = 1'b1;
                        l_next   = l_reg + CW'(1);
                    end
                    state_next = S_QR;
                end
                else
                begin
                    state_next = S_QEND;
                end
            end
            S_QR:
            begin
                if (r_reg[0])
                begin
                    re       = 1'b1;
                    raddr    = r_dec[NW-1:0];
                    mrg_next = 1'b1;
                end
                // odd r: (r-1)>>1 equals r>>1
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = S_QL;
            end
            S_QEND:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load | (out_valid_reg & ~rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            node_reg      <= '0;
            l_reg         <= '0;
            r_reg         <= '0;
            mrg_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            node_reg      <= node_next;
            l_reg         <= l_next;
            r_reg         <= r_next;
            mrg_reg       <= mrg_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= acc_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.range_max = out_data_reg;

    rsmt_ram #(
        .WIDTH (rsmt_pkg::DATA_W),
        .DEPTH (2 * P)
    ) u_nodes (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    rsmt_acc u_acc (
        .clk      (clk),
        .ctl      (ctl),
        .din      (req.value),
        .rdata    (rdata),
        .acc      (acc),
        .acc_next (acc_next)
    );

    // ---- assertions ----

    // leaf store and sibling fetch never hit the same entry
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("node RAM read and write at the same address");

    // query bounds stay ordered while the right side is processed
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QR) |-> (l_reg <= r_reg))
        else $error("query bounds crossed");

    // a result only appears at the end of a query
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_QEND))
        else $error("result raised outside query completion");

    // the write walk never climbs above the root
    a_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRD || state_reg == S_WUP) |-> (node_reg > NW'(1)))
        else $error("write walk reached an invalid node");

endmodule
